// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_BS   = 3'd4,
    PH_U    = 3'd5,
    PH_LOW  = 3'd6
  } phase_e;

  // Record handed from the parser to the byte emitter
  typedef enum logic [1:0] {
    REC_BYTE = 2'd0,
    REC_CP   = 2'd1,
    REC_END  = 2'd2,
    REC_ERR  = 2'd3
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e   kind;
    logic [20:0] data;
    logic [2:0]  code;
  } rec_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_CTRL_CHAR    = 3'd1;
  localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_U        = 3'd3;
  localparam logic [2:0] ERR_MISSING_LOW  = 3'd4;
  localparam logic [2:0] ERR_BAD_LOW      = 3'd5;
  localparam logic [2:0] ERR_BAD_ESC      = 3'd6;
  localparam logic [2:0] ERR_UNTERM_STR   = 3'd7;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

// ===== rtl/jsu_front.sv =====
// Parser front end: string/escape state machine, one record per item at most.
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       push_o,
  output rec_t       rec_o
);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [1:0]  dc_q, dc_d;
  logic [15:0] hv_q, hv_d;
  logic [9:0]  hb_q, hb_d;
  logic        fail;
  logic [2:0]  fcode;
  logic [4:0]  digit;
  logic [15:0] v;
  logic        c_end;
  logic [7:0]  c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      dc_q    <= '0;
      hv_q    <= '0;
      hb_q    <= '0;
    end else begin
      phase_q <= phase_d;
      dc_q    <= dc_d;
      hv_q    <= hv_d;
      hb_q    <= hb_d;
    end
  end

  assign c     = in_byte_i;
  assign c_end = text_end_i;
  assign digit = hex_val(c);
  assign v     = {hv_q[11:0], digit[3:0]};

  always_comb begin
    phase_d = phase_q;
    dc_d    = dc_q;
    hv_d    = hv_q;
    hb_d    = hb_q;
    push_o  = 1'b0;
    rec_o   = '{kind: REC_BYTE, data: '0, code: ERR_NO_QUOTE};
    fail    = 1'b0;
    fcode   = ERR_NO_QUOTE;
    if (accept_i) begin
      unique case (phase_q)
        PH_STR: begin
          if (c_end) begin
            fail = 1'b1; fcode = ERR_UNTERM_STR;
          end else if (c == ChQuote) begin
            phase_d = PH_WAIT;
            push_o = 1'b1;
            rec_o.kind = REC_END;
          end else if (c < 8'h20) begin
            fail = 1'b1; fcode = ERR_CTRL_CHAR;
          end else if (c == ChBslash) begin
            phase_d = PH_ESC;
          end else begin
            push_o = 1'b1;
            rec_o.data = {13'd0, c};
          end
        end
        PH_ESC: begin
          if (c_end) begin
            fail = 1'b1; fcode = ERR_UNTERM_ESC;
          end else begin
            phase_d = PH_STR;
            push_o = 1'b1;
            case (c)
              ChQuote, ChBslash, ChSlash: rec_o.data = {13'd0, c};
              ChB: rec_o.data = 21'h08;
              ChF: rec_o.data = 21'h0C;
              ChN: rec_o.data = 21'h0A;
              ChR: rec_o.data = 21'h0D;
              ChT: rec_o.data = 21'h09;
              ChU: begin
                push_o  = 1'b0;
                phase_d = PH_HEX;
                dc_d    = '0;
                hv_d    = '0;
              end
              default: begin
                push_o = 1'b0;
                fail = 1'b1; fcode = ERR_BAD_ESC;
              end
            endcase
          end
        end
        PH_HEX, PH_LOW: begin
          if (c_end || !digit[4]) begin
            fail = 1'b1;
            fcode = (phase_q == PH_HEX) ? ERR_BAD_U : ERR_BAD_LOW;
          end else if (dc_q != 2'd3) begin
            hv_d = v;
            dc_d = dc_q + 2'd1;
          end else begin
            dc_d = '0;
            hv_d = v;
            if (phase_q == PH_HEX) begin
              if (v[15:10] == 6'b110110) begin
                hb_d    = v[9:0];
                phase_d = PH_BS;
              end else begin
                phase_d    = PH_STR;
                push_o     = 1'b1;
                rec_o.kind = REC_CP;
                rec_o.data = {5'd0, v};
              end
            end else if (v[15:10] != 6'b110111) begin
              fail = 1'b1; fcode = ERR_BAD_LOW;
            end else begin
              phase_d    = PH_STR;
              push_o     = 1'b1;
              rec_o.kind = REC_CP;
              rec_o.data = 21'h10000 + {1'b0, hb_q, v[9:0]};
            end
          end
        end
        PH_BS: begin
          if (c_end || c != ChBslash) begin
            fail = 1'b1; fcode = ERR_MISSING_LOW;
          end else begin
            phase_d = PH_U;
          end
        end
        PH_U: begin
          if (c_end || c != ChU) begin
            fail = 1'b1; fcode = ERR_MISSING_LOW;
          end else begin
            phase_d = PH_LOW;
            dc_d    = '0;
            hv_d    = '0;
          end
        end
        default: begin
          // waiting for the opening quote; unused code behaves the same
          if (c_end || c != ChQuote) begin
            fail = 1'b1; fcode = ERR_NO_QUOTE;
          end else begin
            phase_d = PH_STR;
          end
        end
      endcase
    end
    if (fail) begin
      phase_d    = PH_WAIT;
      dc_d       = '0;
      hv_d       = '0;
      hb_d       = '0;
      push_o     = 1'b1;
      rec_o.kind = REC_ERR;
      rec_o.data = '0;
      rec_o.code = fcode;
    end
  end

endmodule

// ===== rtl/jsu_fifo.sv =====
// Small record queue between parser and emitter.
module jsu_fifo
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Emitter: expands records into output items, UTF-8 encoding code points.
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rec_t       rec_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o,
  output logic       last_of_run_o
);

  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic [1:0]  kind_q;
  logic [2:0]  code_q;
  logic        last_q;
  logic [1:0]  last_idx;
  logic [7:0]  sel_byte;
  logic [1:0]  sel_kind;
  logic [2:0]  sel_code;
  logic        ld;
  logic [20:0] cp;

  assign cp = rec_i.data;

  always_comb begin
    last_idx = 2'd0;
    sel_byte = 8'h00;
    sel_kind = KIND_DATA;
    sel_code = ERR_NO_QUOTE;
    case (rec_i.kind)
      REC_BYTE: sel_byte = cp[7:0];
      REC_END:  sel_kind = KIND_END;
      REC_ERR: begin
        sel_kind = KIND_ERR;
        sel_code = rec_i.code;
      end
      default: begin
        if (cp <= 21'h7F) begin
          sel_byte = cp[7:0];
        end else if (cp <= 21'h7FF) begin
          last_idx = 2'd1;
          sel_byte = (idx_q == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
          last_idx = 2'd2;
          case (idx_q)
            2'd0:    sel_byte = {4'b1110, cp[15:12]};
            2'd1:    sel_byte = {2'b10, cp[11:6]};
            default: sel_byte = {2'b10, cp[5:0]};
          endcase
        end else begin
          last_idx = 2'd3;
          case (idx_q)
            2'd0:    sel_byte = {5'b11110, cp[20:18]};
            2'd1:    sel_byte = {2'b10, cp[17:12]};
            2'd2:    sel_byte = {2'b10, cp[11:6]};
            default: sel_byte = {2'b10, cp[5:0]};
          endcase
        end
      end
    endcase
  end

  assign ld    = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = ld && (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (ld) begin
      out_valid_q <= 1'b1;
      idx_q       <= (idx_q == last_idx) ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      byte_q <= sel_byte;
      kind_q <= sel_kind;
      code_q <= sel_code;
      last_q <= (idx_q == last_idx);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign kind_o        = kind_q;
  assign error_code_o  = code_q;
  assign last_of_run_o = last_q;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON quoted-string decoder with UTF-8 re-encoding of \u escapes. A text
// item is accepted every cycle while the four-entry record queue between the
// parser and the emitter has room. Each item yields at most one record; the
// emitter turns a record into one output item per cycle while the output is
// not stalled, 1 to 4 for a \u code point. Input stall rises only when the
// queue is full, which follows output stall or a run of multi-byte code
// points. A result is written into the record queue and then registered in
// the emitter's output register before it reaches the output.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o,
  output logic       last_of_run_o
);

  logic accept;
  logic push;
  rec_t push_rec;
  logic q_full;
  logic q_valid;
  logic pop;
  rec_t head_rec;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  jsu_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i   (accept),
    .in_byte_i,
    .text_end_i,
    .push_o     (push),
    .rec_o      (push_rec)
  );

  jsu_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  jsu_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i     (q_valid),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .kind_o,
    .error_code_o,
    .last_of_run_o
  );

`ifndef ASSERT_OFF
  a_end_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> last_of_run_o)
    else $error("end or error item not last of run");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERR |-> error_code_o == ERR_NO_QUOTE)
    else $error("error code set on non-error item");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_valid)
    else $error("queue full without head record");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

// ===== dv/json_string_unescape_utf8_tb.sv =====
// Testbench for the JSON string unescape block: random text with a predictor-driven scoreboard.
`timescale 1ns / 1ps

module tb
  import jsu_pkg::*;
;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [2:0] CODE_NONE = 3'd0;

  // Decodes the text stream in step with the block and keeps the results it owes.
  class unescape_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [2:0] code;
      logic       last;
    } result_t;

    phase_e      phase;
    logic [1:0]  digits;
    logic [15:0] hex_acc;
    logic [9:0]  high_bits;
    result_t     expected_q[$];
    result_t     run_q[$];
    int unsigned mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      phase     = PH_WAIT;
      digits    = 2'd0;
      hex_acc   = 16'h0000;
      high_bits = 10'h000;
    endfunction

    function void add_result(logic [7:0] data, logic [1:0] kind, logic [2:0] code);
      result_t r;
      r = '{data, kind, code, 1'b0};
      run_q.insert(run_q.size(), r);
    endfunction

    function void abort_string(logic [2:0] code);
      clear_state();
      add_result(8'h00, KIND_ERR, code);
    endfunction

    function void emit_code_point(logic [20:0] cp);
      if (cp <= 21'h7F) begin
        add_result(cp[7:0], KIND_DATA, CODE_NONE);
      end else if (cp <= 21'h7FF) begin
        add_result({3'b110, cp[10:6]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[5:0]}, KIND_DATA, CODE_NONE);
      end else if (cp <= 21'hFFFF) begin
        add_result({4'b1110, cp[15:12]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[11:6]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[5:0]}, KIND_DATA, CODE_NONE);
      end else begin
        add_result({5'b11110, cp[20:18]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[17:12]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[11:6]}, KIND_DATA, CODE_NONE);
        add_result({2'b10, cp[5:0]}, KIND_DATA, CODE_NONE);
      end
    endfunction

    function void note_item(logic [7:0] b, logic e);
      logic [4:0]  nib;  // bit 4 set: not a hex digit
      logic [15:0] v;
      result_t     r;
      run_q.delete();
      nib = 5'h10;
      if (!e) begin
        if (b >= "0" && b <= "9") nib = {1'b0, b[3:0]};
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
          nib = {1'b0, b[3:0] + 4'd9};
      end
      v = {hex_acc[11:0], nib[3:0]};
      case (phase)
        PH_STR: begin
          if (e) abort_string(ERR_UNTERM_STR);
          else if (b == CH_QUOTE) begin
            phase = PH_WAIT;
            add_result(8'h00, KIND_END, CODE_NONE);
          end else if (b < 8'h20) abort_string(ERR_CTRL_CHAR);
          else if (b == CH_BSLASH) phase = PH_ESC;
          else add_result(b, KIND_DATA, CODE_NONE);
        end
        PH_ESC: begin
          if (e) abort_string(ERR_UNTERM_ESC);
          else begin
            phase = PH_STR;
            case (b)
              CH_QUOTE, CH_BSLASH, "/": add_result(b, KIND_DATA, CODE_NONE);
              "b": add_result(8'h08, KIND_DATA, CODE_NONE);
              "f": add_result(8'h0C, KIND_DATA, CODE_NONE);
              "n": add_result(8'h0A, KIND_DATA, CODE_NONE);
              "r": add_result(8'h0D, KIND_DATA, CODE_NONE);
              "t": add_result(8'h09, KIND_DATA, CODE_NONE);
              "u": begin
                phase   = PH_HEX;
                digits  = 2'd0;
                hex_acc = 16'h0000;
              end
              default: abort_string(ERR_BAD_ESC);
            endcase
          end
        end
        PH_HEX, PH_LOW: begin
          if (nib[4]) abort_string(phase == PH_HEX ? ERR_BAD_U : ERR_BAD_LOW);
          else if (digits != 2'd3) begin
            hex_acc = v;
            digits  = digits + 2'd1;
          end else begin
            digits  = 2'd0;
            hex_acc = v;
            if (phase == PH_HEX) begin
              if (v >= 16'hD800 && v <= 16'hDBFF) begin
                high_bits = v[9:0];
                phase     = PH_BS;
              end else begin
                phase = PH_STR;
                emit_code_point({5'd0, v});
              end
            end else if (v < 16'hDC00 || v > 16'hDFFF) abort_string(ERR_BAD_LOW);
            else begin
              phase = PH_STR;
              emit_code_point(21'h10000 + {1'b0, high_bits, v[9:0]});
            end
          end
        end
        PH_BS: begin
          if (e || b != CH_BSLASH) abort_string(ERR_MISSING_LOW);
          else phase = PH_U;
        end
        PH_U: begin
          if (e || b != "u") abort_string(ERR_MISSING_LOW);
          else begin
            phase   = PH_LOW;
            digits  = 2'd0;
            hex_acc = 16'h0000;
          end
        end
        default: begin
          if (e || b != CH_QUOTE) abort_string(ERR_NO_QUOTE);
          else phase = PH_STR;
        end
      endcase
      foreach (run_q[i]) begin
        r = run_q[i];
        r.last = (i == run_q.size() - 1);
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind, logic [2:0] code,
                               logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h kind %0d code %0d last %0b",
                   data, kind, code, last);
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data || kind !== want.kind || code !== want.code ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want byte %02h kind %0d code %0d last %0b, got %02h %0d %0d %0b",
                   want.data, want.kind, want.code, want.last, data, kind, code, last);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  typedef struct {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       text_end  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] error_code_o;
  logic       last_of_run_o;

  unescape_scoreboard sb = new();
  text_item_t  text_q[$];
  int unsigned items_sent = 0;
  bit          in_calm    = 1'b0;
  bit          out_calm   = 1'b0;
  logic [7:0]  esc_tab [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

  json_string_unescape_utf8 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte),
    .text_end_i   (text_end),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_valid && !in_stall_o) sb.note_item(in_byte, text_end);
    if (out_valid_o && !out_stall)
      sb.check_result(out_byte_o, kind_o, error_code_o, last_of_run_o);
  end

  // Occasionally flips into a calm stretch where no gaps are inserted.
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
  endfunction

  function automatic void queue_text(logic [7:0] b, logic e = 1'b0);
    text_item_t t;
    t = '{b, e};
    text_q.insert(text_q.size(), t);
  endfunction

  function automatic void queue_chars(string s);
    for (int i = 0; i < s.len(); i++) queue_text(s[i]);
  endfunction

  function automatic void queue_escape_u(logic [15:0] v);
    queue_text(CH_BSLASH);
    queue_text("u");
    for (int k = 3; k >= 0; k--) queue_text(hex_char(v[4*k +: 4]));
  endfunction

  // One piece of string body; with allow_bad a surrogate pair may be left broken.
  function automatic void queue_piece(bit allow_bad);
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
        queue_text(b);
      end
      4, 5: begin
        queue_text(CH_BSLASH);
        queue_text(esc_tab[$urandom_range(0, 7)]);
      end
      6: queue_escape_u(16'($urandom_range(0, 16'h7FF)));
      7: begin
        do v = 16'($urandom); while (v >= 16'hD800 && v <= 16'hDFFF);
        queue_escape_u(v);
      end
      8: begin
        queue_escape_u(16'($urandom_range(16'hD800, 16'hDBFF)));
        if (allow_bad && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1)) begin
            do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
            queue_escape_u(v);
          end
        end else queue_escape_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      default: queue_escape_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
    endcase
  endfunction

  function automatic void queue_string(bit allow_bad);
    queue_text(CH_QUOTE);
    repeat ($urandom_range(0, 6)) queue_piece(allow_bad);
    queue_text(CH_QUOTE);
  endfunction

  // Truncated string plus a stray byte or text end; a final text end resyncs.
  function automatic void queue_broken();
    int unsigned cut;
    queue_string(1'b1);
    cut = $urandom_range(1, text_q.size() - 1);
    while (text_q.size() > cut) void'(text_q.pop_back());
    case ($urandom_range(0, 2))
      0:       queue_text(8'($urandom), 1'b1);
      1:       queue_text(8'($urandom_range(0, 8'h1F)));
      default: queue_text(8'($urandom));
    endcase
    queue_text(8'($urandom), 1'b1);
  endfunction

  task automatic send_item(logic [7:0] b, logic e);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    text_end <= e;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i].b, text_q[i].e);
    items_sent += text_q.size();
    text_q.delete();
  endtask

  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      int unsigned gap;
      gap = draw_gap(out_calm);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned sel;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray bytes and text end while waiting, byte extremes, the largest
    // surrogate pair, a lone low surrogate, a bad escape and a control char.
    queue_text(8'h00);
    queue_text(8'hA5, 1'b1);
    queue_chars("\"");
    queue_text(8'hFF);
    queue_text(8'h20);
    queue_chars("\\uDBff\\uDFFF\\udc00\\q\"");
    queue_text(8'h1F);
    send_text();

    while (items_sent < 170) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) queue_string(1'b0);
      else if (sel < 9) queue_broken();
      else repeat ($urandom_range(1, 3)) queue_text(8'($urandom), $urandom_range(0, 3) == 0);
      send_text();
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
